>>> hdl/clipped_rect_blitter_unit_assert.svh
// Assertion macros for the clipped rectangle blitter.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef CLIPPED_RECT_BLITTER_UNIT_ASSERT_SVH
`define CLIPPED_RECT_BLITTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define CRBU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("clipped_rect_blitter_unit: check failed");

// The consequent must hold in the cycle after the antecedent.
`define CRBU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("clipped_rect_blitter_unit: check failed");

`else

`define CRBU_ASSERT_IMPL(label, ante, cons)
`define CRBU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> hdl/crbu_pkg.sv
package crbu_pkg;

	localparam int COORD_W  = 12;
	localparam int CFG_W    = 13;
	localparam int ADDR_W   = 24;
	localparam int COLOR_W  = 32;
	localparam int GLYPH_W  = 8;
	localparam int CIDX_W   = 2;

	localparam int MAX_DIM         = 4096;
	localparam int GLYPH_MAX_WIDTH = 8;

	localparam logic [COORD_W-1:0] DIM_LIMIT     = COORD_W'(MAX_DIM - 1);
	localparam logic [COORD_W-1:0] GLYPH_W_LIMIT = COORD_W'(GLYPH_MAX_WIDTH);
	localparam logic [COLOR_W-1:0] COLOR_KEY     = 32'h00FF_00FF;

	localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
	localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;
	localparam logic [CFG_W-1:0] LINE_PITCH_RST    = 13'd1024;

	typedef enum logic [1:0] {
		ACT_FILL  = 2'd0,
		ACT_IMAGE = 2'd1,
		ACT_GLYPH = 2'd2,
		ACT_STEP  = 2'd3
	} action_t;

	typedef enum logic [CIDX_W-1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_LINE_PITCH    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] area_width;
		logic [COORD_W-1:0] area_height;
		logic [COLOR_W-1:0] draw_color;
		logic [GLYPH_W-1:0] glyph_code;
		logic [COLOR_W-1:0] source_data;
	} item_t;

	typedef struct packed {
		logic               write_enable;
		logic [ADDR_W-1:0]  pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic [ADDR_W-1:0]  next_source_index;
		logic               command_done;
	} result_t;

endpackage

>>> hdl/crbu_item_if.sv
interface crbu_item_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     action;
	logic [crbu_pkg::COORD_W-1:0]   origin_x;
	logic [crbu_pkg::COORD_W-1:0]   origin_y;
	logic [crbu_pkg::COORD_W-1:0]   area_width;
	logic [crbu_pkg::COORD_W-1:0]   area_height;
	logic [crbu_pkg::COLOR_W-1:0]   draw_color;
	logic [crbu_pkg::GLYPH_W-1:0]   glyph_code;
	logic [crbu_pkg::COLOR_W-1:0]   source_data;

	modport source (
		output valid, action, origin_x, origin_y, area_width, area_height,
			draw_color, glyph_code, source_data,
		input  ready
	);

	modport sink (
		input  valid, action, origin_x, origin_y, area_width, area_height,
			draw_color, glyph_code, source_data,
		output ready
	);
endinterface

>>> hdl/crbu_result_if.sv
interface crbu_result_if;
	logic                           valid;
	logic                           ready;
	logic                           write_enable;
	logic [crbu_pkg::ADDR_W-1:0]    pixel_address;
	logic [crbu_pkg::COLOR_W-1:0]   pixel_color;
	logic [crbu_pkg::ADDR_W-1:0]    next_source_index;
	logic                           command_done;

	modport source (
		output valid, write_enable, pixel_address, pixel_color, next_source_index,
			command_done,
		input  ready
	);

	modport sink (
		input  valid, write_enable, pixel_address, pixel_color, next_source_index,
			command_done,
		output ready
	);
endinterface

>>> hdl/clipped_rect_blitter_unit.sv
// An accepted transaction passes through the input register (stage 1) and then the result
// register (stage 2) before its result is valid; a waiting result can hold it in stage 1.
// One transaction per cycle while results are taken; the command state feeds back to stage 1.
// Reset (arst_n low, asynchronous): both stages empty, no command running,
// screen 1024 x 768 with a pitch of 1024 pixels.
`include "clipped_rect_blitter_unit_assert.svh"

module clipped_rect_blitter_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [crbu_pkg::CIDX_W-1:0]   cfg_index,
	input  logic [crbu_pkg::CFG_W-1:0]    cfg_data,
	crbu_item_if.sink                     items,
	crbu_result_if.source                 results
);

	// The block is a two-register pipeline. Stage 1 holds the accepted
	// transaction; the command state and the result register are both
	// loaded from it in a single pass of logic. Because the state is written
	// on the same edge that moves an item into the result register, the
	// next item in stage 1 always sees the state its predecessor left.

	// Configuration registers.
	logic [crbu_pkg::CFG_W-1:0] screen_width_q;
	logic [crbu_pkg::CFG_W-1:0] screen_height_q;
	logic [crbu_pkg::CFG_W-1:0] line_pitch_q;

	// Pipeline handshake.
	logic                valid_s1;
	crbu_pkg::item_t     item_s1;
	logic                valid_s2;
	crbu_pkg::result_t   res_s2;
	logic                advance_s2;
	logic                fire_s1;

	// Command state.
	logic                          busy_q;
	crbu_pkg::action_t             mode_q;
	logic [crbu_pkg::COORD_W-1:0]  start_col_q;
	logic [crbu_pkg::COORD_W-1:0]  start_row_q;
	logic [crbu_pkg::COORD_W-1:0]  full_w_q;
	logic [crbu_pkg::COORD_W-1:0]  full_h_q;
	logic [crbu_pkg::COORD_W-1:0]  clip_w_q;
	logic [crbu_pkg::COORD_W-1:0]  clip_h_q;
	logic [crbu_pkg::COORD_W-1:0]  col_q;
	logic [crbu_pkg::COORD_W-1:0]  row_q;
	logic [crbu_pkg::COLOR_W-1:0]  color_q;
	logic [crbu_pkg::ADDR_W-1:0]   glyph_base_q;
	logic [crbu_pkg::ADDR_W-1:0]   pix_q;

	// Next-state and result values.
	logic                          busy_d;
	logic [crbu_pkg::COORD_W-1:0]  full_w_d;
	logic [crbu_pkg::COORD_W-1:0]  full_h_d;
	logic [crbu_pkg::COORD_W-1:0]  clip_w_d;
	logic [crbu_pkg::COORD_W-1:0]  clip_h_d;
	logic [crbu_pkg::COORD_W-1:0]  col_d;
	logic [crbu_pkg::COORD_W-1:0]  row_d;
	logic [crbu_pkg::ADDR_W-1:0]   glyph_base_d;
	logic [crbu_pkg::ADDR_W-1:0]   pix_d;
	crbu_pkg::result_t             res_d;

	// Start decode.
	logic                          is_start;
	logic [crbu_pkg::COORD_W-1:0]  w_clamp;
	logic [crbu_pkg::COORD_W-1:0]  h_clamp;
	logic [crbu_pkg::COORD_W-1:0]  st_w;
	logic [crbu_pkg::CFG_W-1:0]    room_x;
	logic [crbu_pkg::CFG_W-1:0]    room_y;
	logic                          st_ok;
	logic [crbu_pkg::GLYPH_W+crbu_pkg::COORD_W-1:0] glyph_prod;

	// Step datapath.
	logic [crbu_pkg::CFG_W-1:0]    row_abs;
	logic [crbu_pkg::CFG_W-1:0]    col_abs;
	logic [2*crbu_pkg::CFG_W-1:0]  addr_sum;
	logic [crbu_pkg::CFG_W-1:0]    col_inc;
	logic [crbu_pkg::CFG_W-1:0]    row_inc;
	logic                          col_wrap;
	logic                          last_step;
	logic                          in_clip;
	logic                          step_we;
	logic [crbu_pkg::COLOR_W-1:0]  step_color;
	logic [crbu_pkg::ADDR_W-1:0]   step_nidx;
	logic [crbu_pkg::GLYPH_W-1:0]  font_row;

	// Configuration writes. Software must write only between transactions; the block
	// does not enforce this and has no interlock against the datapath. Index three is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= crbu_pkg::SCREEN_WIDTH_RST;
			screen_height_q <= crbu_pkg::SCREEN_HEIGHT_RST;
			line_pitch_q    <= crbu_pkg::LINE_PITCH_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				crbu_pkg::REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				crbu_pkg::REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				crbu_pkg::REG_LINE_PITCH:    line_pitch_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake. Stage 1 drains whenever the result register is empty or
	// being taken, so a waiting result blocks a new transaction only when
	// stage 1 is also full.
	assign advance_s2  = !valid_s2 || results.ready;
	assign fire_s1     = valid_s1 && advance_s2;
	assign items.ready = !valid_s1 || advance_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (items.ready) begin
				valid_s1 <= items.valid;
			end
			if (advance_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.action      <= items.action;
			item_s1.origin_x    <= items.origin_x;
			item_s1.origin_y    <= items.origin_y;
			item_s1.area_width  <= items.area_width;
			item_s1.area_height <= items.area_height;
			item_s1.draw_color  <= items.draw_color;
			item_s1.glyph_code  <= items.glyph_code;
			item_s1.source_data <= items.source_data;
		end
		if (fire_s1) begin
			res_s2 <= res_d;
		end
	end

	// Start path: clamp the area, drop commands whose origin is off screen or
	// whose area is empty, and clip the area against the screen edges.
	assign is_start = (item_s1.action != crbu_pkg::ACT_STEP);
	assign w_clamp  = (item_s1.area_width > crbu_pkg::DIM_LIMIT) ?
		crbu_pkg::DIM_LIMIT : item_s1.area_width;
	assign h_clamp  = (item_s1.area_height > crbu_pkg::DIM_LIMIT) ?
		crbu_pkg::DIM_LIMIT : item_s1.area_height;
	assign st_w     = (item_s1.action == crbu_pkg::ACT_GLYPH &&
		w_clamp > crbu_pkg::GLYPH_W_LIMIT) ? crbu_pkg::GLYPH_W_LIMIT : w_clamp;
	assign room_x   = screen_width_q - {1'b0, item_s1.origin_x};
	assign room_y   = screen_height_q - {1'b0, item_s1.origin_y};
	assign st_ok    = ({1'b0, item_s1.origin_x} < screen_width_q) &&
		({1'b0, item_s1.origin_y} < screen_height_q) &&
		(st_w != '0) && (h_clamp != '0);
	// First font word of a glyph: glyph code times cell height.
	assign glyph_prod = item_s1.glyph_code * h_clamp;

	// Step path. The address multiply uses the live pitch register, since
	// software may retune the pitch between steps of one command.
	assign row_abs  = {1'b0, start_row_q} + {1'b0, row_q};
	assign col_abs  = {1'b0, start_col_q} + {1'b0, col_q};
	assign addr_sum = row_abs * line_pitch_q + {crbu_pkg::CFG_W'(0), col_abs};
	assign col_inc  = {1'b0, col_q} + crbu_pkg::CFG_W'(1);
	assign col_wrap = (col_inc >= {1'b0, full_w_q});
	assign row_inc  = col_wrap ? ({1'b0, row_q} + crbu_pkg::CFG_W'(1)) : {1'b0, row_q};
	assign last_step = (row_inc >= {1'b0, full_h_q});
	assign in_clip  = (col_q < clip_w_q) && (row_q < clip_h_q);
	assign font_row = item_s1.source_data[crbu_pkg::GLYPH_W-1:0];

	// Pixel decision per mode. The glyph row byte is read from bit 7 down
	// as the column walks right; columns past the eighth never draw.
	always_comb begin
		step_we    = 1'b0;
		step_color = '0;
		step_nidx  = '0;
		case (mode_q)
			crbu_pkg::ACT_FILL: begin
				step_we = in_clip;
			end
			crbu_pkg::ACT_IMAGE: begin
				step_we   = in_clip && (item_s1.source_data != crbu_pkg::COLOR_KEY);
				// Row-major walk over the full width: the source index is
				// simply the number of pixels walked so far.
				step_nidx = pix_q + crbu_pkg::ADDR_W'(1);
			end
			crbu_pkg::ACT_GLYPH: begin
				step_we   = in_clip && (col_q < crbu_pkg::GLYPH_W_LIMIT) &&
					font_row[3'(crbu_pkg::GLYPH_MAX_WIDTH - 1) - col_q[2:0]];
				step_nidx = glyph_base_q + crbu_pkg::ADDR_W'(row_inc);
			end
			default: ;
		endcase
		if (step_we) begin
			step_color = (mode_q == crbu_pkg::ACT_IMAGE) ? item_s1.source_data : color_q;
		end
	end

	// Next state and the result for the item in stage 1.
	always_comb begin
		busy_d       = busy_q;
		full_w_d     = full_w_q;
		full_h_d     = full_h_q;
		clip_w_d     = clip_w_q;
		clip_h_d     = clip_h_q;
		col_d        = col_q;
		row_d        = row_q;
		glyph_base_d = glyph_base_q;
		pix_d        = pix_q;
		res_d        = '0;
		res_d.command_done = 1'b1;
		if (is_start) begin
			full_w_d     = st_w;
			full_h_d     = h_clamp;
			col_d        = '0;
			row_d        = '0;
			pix_d        = '0;
			glyph_base_d = crbu_pkg::ADDR_W'(glyph_prod);
			busy_d       = st_ok;
			if (st_ok) begin
				clip_w_d = ({1'b0, st_w} < room_x) ? st_w : room_x[crbu_pkg::COORD_W-1:0];
				clip_h_d = ({1'b0, h_clamp} < room_y) ?
					h_clamp : room_y[crbu_pkg::COORD_W-1:0];
				res_d.command_done = 1'b0;
				if (item_s1.action == crbu_pkg::ACT_GLYPH) begin
					res_d.next_source_index = crbu_pkg::ADDR_W'(glyph_prod);
				end
			end else begin
				clip_w_d = '0;
				clip_h_d = '0;
			end
		end else if (busy_q) begin
			res_d.write_enable  = step_we;
			res_d.pixel_address = addr_sum[crbu_pkg::ADDR_W-1:0];
			res_d.pixel_color   = step_color;
			pix_d               = pix_q + crbu_pkg::ADDR_W'(1);
			if (last_step) begin
				busy_d = 1'b0;
				col_d  = '0;
				row_d  = '0;
			end else begin
				col_d = col_wrap ? '0 : col_inc[crbu_pkg::COORD_W-1:0];
				row_d = row_inc[crbu_pkg::COORD_W-1:0];
				res_d.command_done      = 1'b0;
				res_d.next_source_index = step_nidx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
			pix_q  <= '0;
		end else if (fire_s1) begin
			busy_q <= busy_d;
			col_q  <= col_d;
			row_q  <= row_d;
			pix_q  <= pix_d;
		end
	end

	// Command parameters only matter while busy, so they carry no reset.
	always_ff @(posedge clk) begin
		if (fire_s1) begin
			full_w_q     <= full_w_d;
			full_h_q     <= full_h_d;
			clip_w_q     <= clip_w_d;
			clip_h_q     <= clip_h_d;
			glyph_base_q <= glyph_base_d;
			if (is_start) begin
				mode_q      <= crbu_pkg::action_t'(item_s1.action);
				start_col_q <= item_s1.origin_x;
				start_row_q <= item_s1.origin_y;
				color_q     <= item_s1.draw_color;
			end
		end
	end

	assign results.valid             = valid_s2;
	assign results.write_enable      = res_s2.write_enable;
	assign results.pixel_address     = res_s2.pixel_address;
	assign results.pixel_color       = res_s2.pixel_color;
	assign results.next_source_index = res_s2.next_source_index;
	assign results.command_done      = res_s2.command_done;

	// With no command running the walk counters rest at the origin.
	`CRBU_ASSERT_IMPL(a_idle_counters, !busy_q, col_q == '0 && row_q == '0)
	// A running command keeps its walk inside the unclipped area.
	`CRBU_ASSERT_IMPL(a_walk_bounds, busy_q, col_q < full_w_q && row_q < full_h_q)
	// A step that clears busy must have reported the end of its command.
	`CRBU_ASSERT_NEXT(a_done_on_finish, fire_s1 && busy_q && !is_start && !busy_d,
		res_s2.command_done && res_s2.next_source_index == '0)

endmodule
